/* rtl/gcre_pkg.sv */
// Shared types and constants for the grid cell range enumerator.
`default_nettype none
package gcre_pkg;

  localparam int NUM_LANES = 6;
  localparam int AXES      = 3;
  localparam int IN_W      = 32;
  localparam int CS_W      = 24;
  localparam int QW        = 15;
  localparam int CELL_W    = 16;
  localparam int DIV_W     = CS_W + QW;

  localparam logic [QW-1:0]   INDEX_LIMIT   = 15'd32766;
  localparam logic [CS_W-1:0] CELL_SIZE_RST = 24'd16384;

  typedef logic [IN_W-1:0] mag_t;
  typedef logic signed [CELL_W-1:0] cell_t;

  // One corner component on its way through the divider, in sign and magnitude.
  typedef struct packed {
    mag_t          rem;
    logic [QW-1:0] quo;
    logic          neg;
    logic          ovf;
  } lane_t;

  // Cell range of one box after the division.
  typedef struct packed {
    cell_t [AXES-1:0] lo;
    cell_t [AXES-1:0] hi;
    logic             empty;
  } box_t;

endpackage
`default_nettype wire

/* rtl/gcre_prep.sv */
// Input stage: corner magnitudes, signs and quotient overflow detection.
`default_nettype none
module gcre_prep (
  input  wire                                          clk,
  input  wire                                          rst_n,
  input  wire                                          adv,
  input  wire                                          valid_i,
  input  wire  [gcre_pkg::NUM_LANES-1:0][gcre_pkg::IN_W-1:0] coord_i,
  input  wire  [gcre_pkg::CS_W-1:0]                    cs_i,
  output logic                                         valid_o,
  output gcre_pkg::lane_t [gcre_pkg::NUM_LANES-1:0]    lanes_o
);

  logic                                      valid_r;
  gcre_pkg::lane_t [gcre_pkg::NUM_LANES-1:0] lanes_r;
  gcre_pkg::lane_t [gcre_pkg::NUM_LANES-1:0] lanes_nxt;

  always_comb begin
    for (int l = 0; l < gcre_pkg::NUM_LANES; l++) begin
      lanes_nxt[l].neg = coord_i[l][gcre_pkg::IN_W-1];
      lanes_nxt[l].rem = coord_i[l][gcre_pkg::IN_W-1] ? (~coord_i[l] + 1'b1) : coord_i[l];
      lanes_nxt[l].quo = '0;
      // A magnitude of cs * 2^QW or more cannot fit the quotient and saturates.
      lanes_nxt[l].ovf = {{(gcre_pkg::DIV_W-gcre_pkg::IN_W){1'b0}}, lanes_nxt[l].rem} >=
                         {cs_i, {gcre_pkg::QW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lanes_r <= lanes_nxt;
    end
  end

  assign valid_o = valid_r;
  assign lanes_o = lanes_r;

endmodule
`default_nettype wire

/* rtl/gcre_div_pipe.sv */
// Pipelined restoring divider: one quotient bit per stage for all six lanes.
`default_nettype none
module gcre_div_pipe (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        adv,
  input  wire                                        valid_i,
  input  gcre_pkg::lane_t [gcre_pkg::NUM_LANES-1:0]  lanes_i,
  input  wire  [gcre_pkg::CS_W-1:0]                  cs_i,
  output logic                                       valid_o,
  output gcre_pkg::lane_t [gcre_pkg::NUM_LANES-1:0]  lanes_o
);

  wire [gcre_pkg::QW:0]                           vld;
  wire gcre_pkg::lane_t [gcre_pkg::NUM_LANES-1:0] stg [gcre_pkg::QW+1];

  assign vld[0] = valid_i;
  assign stg[0] = lanes_i;

  for (genvar s = 0; s < gcre_pkg::QW; s++) begin : g_stage
    localparam int BITPOS = gcre_pkg::QW - 1 - s;

    logic                                      vld_r;
    gcre_pkg::lane_t [gcre_pkg::NUM_LANES-1:0] lane_r;
    gcre_pkg::lane_t [gcre_pkg::NUM_LANES-1:0] lane_nxt;
    logic [gcre_pkg::DIV_W-1:0]                dvs;

    assign dvs = {{gcre_pkg::QW{1'b0}}, cs_i} << BITPOS;

    always_comb begin
      for (int l = 0; l < gcre_pkg::NUM_LANES; l++) begin
        lane_nxt[l] = stg[s][l];
        if ({{(gcre_pkg::DIV_W-gcre_pkg::IN_W){1'b0}}, stg[s][l].rem} >= dvs) begin
          lane_nxt[l].rem = stg[s][l].rem - dvs[gcre_pkg::IN_W-1:0];
          lane_nxt[l].quo = stg[s][l].quo | (gcre_pkg::QW'(1) << BITPOS);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (adv) begin
        vld_r <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        lane_r <= lane_nxt;
      end
    end

    assign vld[s+1] = vld_r;
    assign stg[s+1] = lane_r;
  end

  assign valid_o = vld[gcre_pkg::QW];
  assign lanes_o = stg[gcre_pkg::QW];

endmodule
`default_nettype wire

/* rtl/gcre_fix.sv */
// Output stage of the divider: clamp, floor rounding and the inverted-box check.
`default_nettype none
module gcre_fix (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        adv,
  input  wire                                        valid_i,
  input  gcre_pkg::lane_t [gcre_pkg::NUM_LANES-1:0]  lanes_i,
  output logic                                       valid_o,
  output gcre_pkg::box_t                             box_o
);

  logic                                       valid_r;
  gcre_pkg::box_t                             box_r;
  gcre_pkg::box_t                             box_nxt;
  gcre_pkg::cell_t [gcre_pkg::NUM_LANES-1:0]  cell_idx;

  function automatic gcre_pkg::cell_t to_cell(input gcre_pkg::lane_t l);
    logic                  sat;
    logic                  rnz;
    logic [gcre_pkg::QW-1:0] q;
    gcre_pkg::cell_t       mag;
    sat = l.ovf || (l.quo > gcre_pkg::INDEX_LIMIT) ||
          ((l.quo == gcre_pkg::INDEX_LIMIT) && (l.rem != '0));
    q   = sat ? gcre_pkg::INDEX_LIMIT : l.quo;
    rnz = !sat && (l.rem != '0);
    mag = gcre_pkg::cell_t'({1'b0, q});
    if (!l.neg) begin
      return mag;
    end else if (rnz) begin
      // Negative with a remainder: floor is one below the negated quotient.
      return ~mag;
    end else begin
      return gcre_pkg::cell_t'(0) - mag;
    end
  endfunction

  always_comb begin
    for (int l = 0; l < gcre_pkg::NUM_LANES; l++) begin
      cell_idx[l] = to_cell(lanes_i[l]);
    end
    box_nxt.empty = 1'b0;
    for (int a = 0; a < gcre_pkg::AXES; a++) begin
      box_nxt.lo[a] = cell_idx[a];
      box_nxt.hi[a] = cell_idx[a + gcre_pkg::AXES];
      if ($signed(cell_idx[a]) > $signed(cell_idx[a + gcre_pkg::AXES])) begin
        box_nxt.empty = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      box_r <= box_nxt;
    end
  end

  assign valid_o = valid_r;
  assign box_o   = box_r;

endmodule
`default_nettype wire

/* rtl/gcre_walk.sv */
// Cell walker: steps through the cells of one box, z fastest, one per transfer.
`default_nettype none
module gcre_walk #(
  parameter int MAX_CELLS = 64
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         box_valid_i,
  input  gcre_pkg::box_t              box_i,
  output logic                        ready_o,
  output logic                        out_tvalid,
  input  wire                         out_tready,
  output logic [3*gcre_pkg::CELL_W-1:0] out_tdata,
  output logic                        out_tlast,
  output logic                        out_tuser
);

  localparam int CNT_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

  logic                                  busy_r;
  gcre_pkg::cell_t [gcre_pkg::AXES-1:0]  lo_r;
  gcre_pkg::cell_t [gcre_pkg::AXES-1:0]  hi_r;
  gcre_pkg::cell_t                       x_r, y_r, z_r;
  gcre_pkg::cell_t                       x_nxt, y_nxt, z_nxt;
  logic [CNT_W-1:0]                      n_r;
  logic                                  x_end, y_end, z_end, final_cell, cap;
  logic                                  take, load;

  assign x_end      = (x_r == hi_r[0]);
  assign y_end      = (y_r == hi_r[1]);
  assign z_end      = (z_r == hi_r[2]);
  assign final_cell = x_end && y_end && z_end;
  assign cap        = (n_r == CNT_W'(MAX_CELLS - 1));

  assign take    = busy_r && out_tready;
  assign ready_o = !busy_r || (out_tready && out_tlast);
  assign load    = box_valid_i && ready_o;

  always_comb begin
    z_nxt = z_end ? lo_r[2] : z_r + 1'b1;
    y_nxt = z_end ? (y_end ? lo_r[1] : y_r + 1'b1) : y_r;
    x_nxt = (z_end && y_end) ? x_r + 1'b1 : x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load) begin
      busy_r <= !box_i.empty;
    end else if (take && out_tlast) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lo_r <= box_i.lo;
      hi_r <= box_i.hi;
      x_r  <= box_i.lo[0];
      y_r  <= box_i.lo[1];
      z_r  <= box_i.lo[2];
      n_r  <= '0;
    end else if (take) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      n_r <= n_r + 1'b1;
    end
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = {z_r, y_r, x_r};
  assign out_tlast  = final_cell || cap;
  assign out_tuser  = cap && !final_cell;

endmodule
`default_nettype wire

/* rtl/grid_cell_range_enumerator_top.sv */
// Top level of the grid cell range enumerator.
// Each box transfer on the input carries a minimum and a maximum corner in signed
// Q24.8; every corner component is clamped to plus or minus cell_size * 32766 and
// floor-divided by cell_size, and the block then sends one output transfer per grid
// cell in the box, x outermost, y next and z innermost. The division runs through a
// 17-stage pipeline (one stage for magnitudes, fifteen restoring stages producing one
// quotient bit each, one stage for clamping, floor rounding and the inverted-box
// check); boxes can enter one per cycle while the walker is free. The walker sends one
// cell per cycle while out_tready is high, min(N, MAX_CELLS) of them for a box of N
// cells; the pipeline stalls only while a finished box waits in the last stage and
// the walker cannot take it. The next box is taken in the cycle of the current box's
// last transfer, so output runs back to back. A box that is inverted on any axis
// produces no transfer. If a box holds more than MAX_CELLS cells only the first
// MAX_CELLS are sent and the last carries tuser. A cell_size of zero acts as one.
// cfg_wdata should only be written while no box is in flight.
`default_nettype none
module grid_cell_range_enumerator_top #(
  parameter int MAX_CELLS = 64
) (
  input  wire          clk,
  input  wire          rst_n,
  // Configuration: cell_size, unsigned Q16.8.
  input  wire          cfg_wen,
  input  wire  [23:0]  cfg_wdata,
  // Box input.
  input  wire          in_tvalid,
  output logic         in_tready,
  // box_min_x [31:0], box_min_y [63:32], box_min_z [95:64],
  // box_max_x [127:96], box_max_y [159:128], box_max_z [191:160]
  input  wire  [191:0] in_tdata,
  // Cell output.
  output logic         out_tvalid,
  input  wire          out_tready,
  // cell_x [15:0], cell_y [31:16], cell_z [47:32]
  output logic [47:0]  out_tdata,
  // last_cell
  output logic         out_tlast,
  // truncated
  output logic         out_tuser
);

  logic [gcre_pkg::CS_W-1:0] cell_size_r;
  logic [gcre_pkg::CS_W-1:0] cs_eff;

  logic                                      adv;
  logic                                      prep_valid, div_valid, fix_valid;
  logic                                      walk_ready;
  gcre_pkg::lane_t [gcre_pkg::NUM_LANES-1:0] prep_lanes, div_lanes;
  gcre_pkg::box_t                            fix_box;

  // The cell size register; a zero value is treated as one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= gcre_pkg::CELL_SIZE_RST;
    end else if (cfg_wen) begin
      cell_size_r <= cfg_wdata;
    end
  end

  assign cs_eff = (cell_size_r == '0) ? gcre_pkg::CS_W'(1) : cell_size_r;

  // The whole division pipeline moves together; it holds only when a finished box
  // waits in the last stage and the walker cannot take it yet.
  assign adv       = !fix_valid || walk_ready;
  assign in_tready = adv;

  gcre_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (in_tvalid),
    .coord_i (in_tdata),
    .cs_i    (cs_eff),
    .valid_o (prep_valid),
    .lanes_o (prep_lanes)
  );

  gcre_div_pipe u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (prep_valid),
    .lanes_i (prep_lanes),
    .cs_i    (cs_eff),
    .valid_o (div_valid),
    .lanes_o (div_lanes)
  );

  gcre_fix u_fix (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .valid_i (div_valid),
    .lanes_i (div_lanes),
    .valid_o (fix_valid),
    .box_o   (fix_box)
  );

  gcre_walk #(
    .MAX_CELLS (MAX_CELLS)
  ) u_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .box_valid_i (fix_valid),
    .box_i       (fix_box),
    .ready_o     (walk_ready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule
`default_nettype wire
